// File: sv/tzp_pkg.sv
// Shared constants and helper functions for the time-zone string parser.
package tzp_pkg;

   // Fixed field widths of the items.
   localparam int unsigned BYTE_W   = 8;
   localparam int unsigned OFS_W    = 32;
   localparam int unsigned CFG_W    = 18;
   localparam int unsigned FIELD_W  = 14;
   localparam int unsigned DIGIT_W  = 17;
   localparam int unsigned SUM_W    = 26;

   // Decimal fields stop growing at this value.
   localparam logic [FIELD_W-1:0] FIELD_MAX = 14'd9999;

   localparam logic [SUM_W-1:0] SECS_PER_HOUR = 26'd3600;
   localparam logic [SUM_W-1:0] SECS_PER_MIN  = 26'd60;
   localparam logic [DIGIT_W-1:0] DECIMAL_BASE = 17'd10;

   localparam logic signed [CFG_W-1:0] DEFAULT_OFFSET_RESET = -18'sd28800;

   // Name length reported when the variable is absent.
   localparam int unsigned ABSENT_NAME_LEN = 3;

   // Character codes that steer the parse.
   localparam logic [BYTE_W-1:0] CHAR_NUL   = 8'h00;
   localparam logic [BYTE_W-1:0] CHAR_MINUS = 8'h2D;
   localparam logic [BYTE_W-1:0] CHAR_PLUS  = 8'h2B;
   localparam logic [BYTE_W-1:0] CHAR_COLON = 8'h3A;
   localparam logic [BYTE_W-1:0] CHAR_ZERO  = 8'h30;
   localparam logic [BYTE_W-1:0] CHAR_NINE  = 8'h39;
   localparam logic [BYTE_W-1:0] CHAR_UC_A  = 8'h41;
   localparam logic [BYTE_W-1:0] CHAR_UC_Z  = 8'h5A;
   localparam logic [BYTE_W-1:0] CHAR_LC_A  = 8'h61;
   localparam logic [BYTE_W-1:0] CHAR_LC_Z  = 8'h7A;

   // Letters of the two universal zone names, first letter first.
   function automatic logic [BYTE_W-1:0] gmt_char(input logic [1:0] idx);
      logic [BYTE_W-1:0] ch;
      case (idx)
         2'd0:    ch = 8'h47;
         2'd1:    ch = 8'h4D;
         default: ch = 8'h54;
      endcase
      return ch;
   endfunction

   function automatic logic [BYTE_W-1:0] utc_char(input logic [1:0] idx);
      logic [BYTE_W-1:0] ch;
      case (idx)
         2'd0:    ch = 8'h55;
         2'd1:    ch = 8'h54;
         default: ch = 8'h43;
      endcase
      return ch;
   endfunction

   // One decimal digit appended to a field, saturating.
   function automatic logic [FIELD_W-1:0] add_digit(input logic [FIELD_W-1:0] acc,
                                                    input logic [3:0] digit);
      logic [DIGIT_W-1:0] v;
      v = DIGIT_W'(acc) * DECIMAL_BASE + DIGIT_W'(digit);
      return (v > DIGIT_W'(FIELD_MAX)) ? FIELD_MAX : v[FIELD_W-1:0];
   endfunction

endpackage

// File: sv/tz_offset_string_parser.sv
// Time-zone string parser: byte stream in, zone offset and name facts out.
// One item per cycle is sustained while no waiting result holds req_tready low.
// A terminating item (zero byte or absent variable) shows its result on the
// rsp side in the cycle after acceptance; the rsp register holds it until taken.
// While a result waits and is not taken, req_tready is low.
// Synchronous reset clears the parse state and loads the default offset
// of -28800 seconds.
module tz_offset_string_parser #(
   parameter int unsigned TEXT_LIMIT = 63,
   parameter int unsigned NAME_LIMIT = 9,
   localparam int unsigned LEN_W  = $clog2(NAME_LIMIT + 1),
   localparam int unsigned RSP_W  = ((tzp_pkg::OFS_W + LEN_W + 1 + 7) / 8) * 8
) (
   input  logic                         clock,
   input  logic                         reset,
   // Input items.
   input  logic                         req_tvalid,
   output logic                         req_tready,
   input  logic [7:0]                   req_tdata,  // [7:0] text_byte
   input  logic                         req_tuser,  // [0] no_variable
   // Result items.
   output logic                         rsp_tvalid,
   input  logic                         rsp_tready,
   output logic [RSP_W-1:0]             rsp_tdata,  // offset_seconds, name_length,
                                                    // universal_name, zero fill
   output logic                         rsp_tuser,  // [0] used_default
   // Default offset register.
   input  logic                         csr_valid,
   output logic                         csr_ready,
   input  logic [tzp_pkg::CFG_W-1:0]    csr_data
);

   localparam int unsigned BYTES_W = $clog2(TEXT_LIMIT + 1);
   localparam int unsigned PAD_W   = RSP_W - tzp_pkg::OFS_W - LEN_W - 1;

   typedef enum logic [2:0] {
      PH_NAME, PH_SIGN, PH_PLUS, PH_HOURS, PH_HSKIP, PH_MIN, PH_SEC, PH_DONE
   } phase_type;

   phase_type                        phase_ff, phase_in;
   logic [LEN_W-1:0]                 letters_ff, letters_in;
   logic                             gmt_ff, gmt_in;
   logic                             utc_ff, utc_in;
   logic                             minus_ff, minus_in;
   logic [tzp_pkg::FIELD_W-1:0]      hours_ff, hours_in;
   logic [tzp_pkg::FIELD_W-1:0]      minutes_ff, minutes_in;
   logic [tzp_pkg::FIELD_W-1:0]      seconds_ff, seconds_in;
   logic [BYTES_W-1:0]               bytes_ff, bytes_in;
   logic [tzp_pkg::CFG_W-1:0]        default_ff, default_in;

   logic                             rsp_valid_ff, rsp_valid_in;
   logic [tzp_pkg::OFS_W-1:0]        rsp_offset_ff, rsp_offset_in;
   logic [LEN_W-1:0]                 rsp_len_ff, rsp_len_in;
   logic                             rsp_univ_ff, rsp_univ_in;
   logic                             rsp_dflt_ff, rsp_dflt_in;

   logic [7:0]                       ch;
   logic                             absent;
   logic                             req_fire;
   logic                             is_digit;
   logic                             is_alpha;
   logic                             universal;
   logic [tzp_pkg::SUM_W-1:0]        total;
   logic [tzp_pkg::OFS_W-1:0]        magnitude;
   phase_type                        ph;

   assign ch         = req_tdata;
   assign absent     = req_tuser;
   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign req_fire   = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;

   assign is_digit = (ch >= tzp_pkg::CHAR_ZERO) && (ch <= tzp_pkg::CHAR_NINE);
   assign is_alpha = ((ch >= tzp_pkg::CHAR_UC_A) && (ch <= tzp_pkg::CHAR_UC_Z)) ||
                     ((ch >= tzp_pkg::CHAR_LC_A) && (ch <= tzp_pkg::CHAR_LC_Z));

   assign universal = (letters_ff == LEN_W'(3)) && (gmt_ff || utc_ff);
   assign total = tzp_pkg::SUM_W'(hours_ff) * tzp_pkg::SECS_PER_HOUR +
                  tzp_pkg::SUM_W'(minutes_ff) * tzp_pkg::SECS_PER_MIN +
                  tzp_pkg::SUM_W'(seconds_ff);
   assign magnitude = tzp_pkg::OFS_W'(total);

   always_comb begin
      phase_in     = phase_ff;
      letters_in   = letters_ff;
      gmt_in       = gmt_ff;
      utc_in       = utc_ff;
      minus_in     = minus_ff;
      hours_in     = hours_ff;
      minutes_in   = minutes_ff;
      seconds_in   = seconds_ff;
      bytes_in     = bytes_ff;
      default_in   = csr_valid ? csr_data : default_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_offset_in = rsp_offset_ff;
      rsp_len_in   = rsp_len_ff;
      rsp_univ_in  = rsp_univ_ff;
      rsp_dflt_in  = rsp_dflt_ff;

      // The byte after the name is also looked at as sign, and then as '+'.
      ph = phase_ff;
      if (ph == PH_NAME && !is_alpha) begin
         ph = PH_SIGN;
      end
      if (ph == PH_SIGN && ch != tzp_pkg::CHAR_MINUS) begin
         ph = PH_PLUS;
      end

      if (req_fire) begin
         if (absent || ch == tzp_pkg::CHAR_NUL) begin
            rsp_valid_in = 1'b1;
            if (absent) begin
               rsp_offset_in = {{(tzp_pkg::OFS_W - tzp_pkg::CFG_W){default_ff[tzp_pkg::CFG_W-1]}},
                                default_ff};
               rsp_len_in    = LEN_W'(tzp_pkg::ABSENT_NAME_LEN);
               rsp_univ_in   = 1'b0;
               rsp_dflt_in   = 1'b1;
            end else begin
               rsp_offset_in = (minus_ff != universal) ? -magnitude : magnitude;
               rsp_len_in    = letters_ff;
               rsp_univ_in   = universal;
               rsp_dflt_in   = 1'b0;
            end
            phase_in   = PH_NAME;
            letters_in = '0;
            gmt_in     = 1'b1;
            utc_in     = 1'b1;
            minus_in   = 1'b0;
            hours_in   = '0;
            minutes_in = '0;
            seconds_in = '0;
            bytes_in   = '0;
         end else if (bytes_ff < BYTES_W'(TEXT_LIMIT)) begin
            bytes_in = bytes_ff + BYTES_W'(1);
            unique case (ph)
               PH_NAME: begin
                  if (letters_ff < LEN_W'(3)) begin
                     if (ch != tzp_pkg::gmt_char(letters_ff[1:0])) gmt_in = 1'b0;
                     if (ch != tzp_pkg::utc_char(letters_ff[1:0])) utc_in = 1'b0;
                  end
                  if (letters_ff < LEN_W'(NAME_LIMIT)) begin
                     letters_in = letters_ff + LEN_W'(1);
                  end
               end
               PH_SIGN: begin
                  minus_in = 1'b1;
                  phase_in = PH_PLUS;
               end
               PH_PLUS: begin
                  if (ch == tzp_pkg::CHAR_PLUS) begin
                     phase_in = PH_HOURS;
                  end else if (is_digit) begin
                     hours_in = tzp_pkg::add_digit(hours_ff, ch[3:0]);
                     phase_in = PH_HOURS;
                  end else begin
                     phase_in = (ch == tzp_pkg::CHAR_COLON) ? PH_MIN : PH_DONE;
                  end
               end
               PH_HOURS: begin
                  if (is_digit) begin
                     hours_in = tzp_pkg::add_digit(hours_ff, ch[3:0]);
                  end else if (ch == tzp_pkg::CHAR_PLUS) begin
                     phase_in = PH_HSKIP;
                  end else begin
                     phase_in = (ch == tzp_pkg::CHAR_COLON) ? PH_MIN : PH_DONE;
                  end
               end
               PH_HSKIP: begin
                  if (!is_digit && ch != tzp_pkg::CHAR_PLUS) begin
                     phase_in = (ch == tzp_pkg::CHAR_COLON) ? PH_MIN : PH_DONE;
                  end
               end
               PH_MIN: begin
                  if (is_digit) begin
                     minutes_in = tzp_pkg::add_digit(minutes_ff, ch[3:0]);
                  end else begin
                     phase_in = (ch == tzp_pkg::CHAR_COLON) ? PH_SEC : PH_DONE;
                  end
               end
               PH_SEC: begin
                  if (is_digit) begin
                     seconds_in = tzp_pkg::add_digit(seconds_ff, ch[3:0]);
                  end else begin
                     phase_in = PH_DONE;
                  end
               end
               PH_DONE: begin
                  phase_in = PH_DONE;
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_NAME;
         letters_ff   <= '0;
         gmt_ff       <= 1'b1;
         utc_ff       <= 1'b1;
         minus_ff     <= 1'b0;
         hours_ff     <= '0;
         minutes_ff   <= '0;
         seconds_ff   <= '0;
         bytes_ff     <= '0;
         default_ff   <= tzp_pkg::DEFAULT_OFFSET_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         letters_ff   <= letters_in;
         gmt_ff       <= gmt_in;
         utc_ff       <= utc_in;
         minus_ff     <= minus_in;
         hours_ff     <= hours_in;
         minutes_ff   <= minutes_in;
         seconds_ff   <= seconds_in;
         bytes_ff     <= bytes_in;
         default_ff   <= default_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_offset_ff <= rsp_offset_in;
      rsp_len_ff    <= rsp_len_in;
      rsp_univ_ff   <= rsp_univ_in;
      rsp_dflt_ff   <= rsp_dflt_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {PAD_W'(0), rsp_univ_ff, rsp_len_ff, rsp_offset_ff};
   assign rsp_tuser  = rsp_dflt_ff;

   // The counters never pass their limits and the fields never pass saturation.
   a_counts_bounded: assert property (@(posedge clock) disable iff (reset)
      letters_ff <= LEN_W'(NAME_LIMIT) && bytes_ff <= BYTES_W'(TEXT_LIMIT))
      else $error("letter or byte count beyond its limit");

   a_fields_saturate: assert property (@(posedge clock) disable iff (reset)
      hours_ff <= tzp_pkg::FIELD_MAX && minutes_ff <= tzp_pkg::FIELD_MAX &&
      seconds_ff <= tzp_pkg::FIELD_MAX)
      else $error("decimal field beyond saturation value");

   // A terminating item leaves a fresh parse state behind it.
   a_clear_after_result: assert property (@(posedge clock) disable iff (reset)
      (req_fire && (absent || ch == tzp_pkg::CHAR_NUL)) |=>
         (phase_ff == PH_NAME && letters_ff == '0 && bytes_ff == '0 &&
          hours_ff == '0 && rsp_valid_ff))
      else $error("parse state not cleared after a result");

   // A default result always reports a three-letter, non-universal name.
   a_default_shape: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_dflt_ff) |->
         (rsp_len_ff == LEN_W'(tzp_pkg::ABSENT_NAME_LEN) && !rsp_univ_ff))
      else $error("default result with wrong name facts");

endmodule

// File: bench/tz_offset_string_parser_tb.sv
// Self-checking bench for the time-zone string parser: random zone strings in, offsets and name facts checked.
`timescale 1ns / 1ps

module tz_offset_string_parser_tb;

   localparam int NAME_KEEP   = 9;
   localparam int TEXT_KEEP   = 63;
   localparam int RSP_BITS    = 40;
   localparam int CYCLE_LIMIT = 400000;
   localparam int HOLD_CYCLES = 300;
   localparam int PHASE_ITEMS = 300;
   localparam int SETTLE      = 6;

   typedef enum logic [2:0] {
      ST_NAME, ST_SIGN, ST_PLUS, ST_HOURS, ST_HSKIP, ST_MIN, ST_SEC, ST_DONE
   } parse_state_type;

   typedef struct packed {
      logic [tzp_pkg::OFS_W-1:0] offset_seconds;
      logic [3:0]                name_length;
      logic                      universal_name;
      logic                      used_default;
   } zone_result_type;

   class zone_scoreboard;
      logic signed [tzp_pkg::CFG_W-1:0] default_ofs;
      parse_state_type                  state;
      int                               letters;
      int                               bytes_seen;
      logic                             gmt_ok;
      logic                             utc_ok;
      logic                             minus;
      logic [tzp_pkg::FIELD_W-1:0]      hours;
      logic [tzp_pkg::FIELD_W-1:0]      minutes;
      logic [tzp_pkg::FIELD_W-1:0]      seconds;
      string                            gmt_name = "GMT";
      string                            utc_name = "UTC";
      zone_result_type                  pending[$];
      int                               errors;

      function new();
         default_ofs = tzp_pkg::DEFAULT_OFFSET_RESET;
         errors = 0;
         restart();
      endfunction

      function void restart();
         state = ST_NAME;
         letters = 0;
         bytes_seen = 0;
         gmt_ok = 1'b1;
         utc_ok = 1'b1;
         minus = 1'b0;
         hours = '0;
         minutes = '0;
         seconds = '0;
      endfunction

      function void set_default(logic signed [tzp_pkg::CFG_W-1:0] value);
         default_ofs = value;
      endfunction

      function logic [tzp_pkg::FIELD_W-1:0] push_digit(logic [tzp_pkg::FIELD_W-1:0] acc,
                                                        logic [7:0] ch);
         int v;
         v = int'(acc) * 10 + int'(ch) - int'(tzp_pkg::CHAR_ZERO);
         return (v > int'(tzp_pkg::FIELD_MAX)) ? tzp_pkg::FIELD_MAX : tzp_pkg::FIELD_W'(v);
      endfunction

      function void parse_char(logic [7:0] ch);
         logic is_digit;
         logic is_alpha;
         is_digit = ch >= tzp_pkg::CHAR_ZERO && ch <= tzp_pkg::CHAR_NINE;
         is_alpha = (ch >= tzp_pkg::CHAR_UC_A && ch <= tzp_pkg::CHAR_UC_Z) ||
                    (ch >= tzp_pkg::CHAR_LC_A && ch <= tzp_pkg::CHAR_LC_Z);
         if (state == ST_NAME) begin
            if (is_alpha) begin
               if (letters < 3) begin
                  if (ch != gmt_name[letters]) gmt_ok = 1'b0;
                  if (ch != utc_name[letters]) utc_ok = 1'b0;
               end
               if (letters < NAME_KEEP) letters++;
               return;
            end
            state = ST_SIGN;
         end
         // The byte that ends the name is looked at again as a sign, then as a plus.
         if (state == ST_SIGN) begin
            if (ch == tzp_pkg::CHAR_MINUS) begin
               minus = 1'b1;
               state = ST_PLUS;
               return;
            end
            state = ST_PLUS;
         end
         case (state)
            ST_PLUS: begin
               if (ch == tzp_pkg::CHAR_PLUS) state = ST_HOURS;
               else if (is_digit) begin
                  hours = push_digit(hours, ch);
                  state = ST_HOURS;
               end else state = (ch == tzp_pkg::CHAR_COLON) ? ST_MIN : ST_DONE;
            end
            ST_HOURS: begin
               if (is_digit) hours = push_digit(hours, ch);
               else if (ch == tzp_pkg::CHAR_PLUS) state = ST_HSKIP;
               else state = (ch == tzp_pkg::CHAR_COLON) ? ST_MIN : ST_DONE;
            end
            ST_HSKIP: begin
               if (!(is_digit || ch == tzp_pkg::CHAR_PLUS))
                  state = (ch == tzp_pkg::CHAR_COLON) ? ST_MIN : ST_DONE;
            end
            ST_MIN: begin
               if (is_digit) minutes = push_digit(minutes, ch);
               else state = (ch == tzp_pkg::CHAR_COLON) ? ST_SEC : ST_DONE;
            end
            ST_SEC: begin
               if (is_digit) seconds = push_digit(seconds, ch);
               else state = ST_DONE;
            end
            default: ;
         endcase
      endfunction

      function void note_input(logic [7:0] ch, logic absent);
         zone_result_type r;
         logic [tzp_pkg::OFS_W-1:0] total;
         logic universal;
         if (absent) begin
            r.offset_seconds = {{(tzp_pkg::OFS_W-tzp_pkg::CFG_W){default_ofs[tzp_pkg::CFG_W-1]}},
                                default_ofs};
            r.name_length = 4'(tzp_pkg::ABSENT_NAME_LEN);
            r.universal_name = 1'b0;
            r.used_default = 1'b1;
            pending.push_back(r);
            restart();
            return;
         end
         if (ch == tzp_pkg::CHAR_NUL) begin
            universal = (letters == 3) && (gmt_ok || utc_ok);
            total = tzp_pkg::OFS_W'(hours) * tzp_pkg::OFS_W'(tzp_pkg::SECS_PER_HOUR)
                    + tzp_pkg::OFS_W'(minutes) * tzp_pkg::OFS_W'(tzp_pkg::SECS_PER_MIN)
                    + tzp_pkg::OFS_W'(seconds);
            if (minus != universal) total = -total;
            r.offset_seconds = total;
            r.name_length = 4'(letters);
            r.universal_name = universal;
            r.used_default = 1'b0;
            pending.push_back(r);
            restart();
            return;
         end
         if (bytes_seen >= TEXT_KEEP) return;
         bytes_seen++;
         parse_char(ch);
      endfunction

      function void check_result(logic [RSP_BITS-1:0] data, logic user);
         zone_result_type want;
         if (pending.size() == 0) begin
            $display("%0t: result with none outstanding: data %h user %b", $time, data, user);
            errors++;
            return;
         end
         want = pending.pop_front();
         if (data[31:0] != want.offset_seconds) begin
            $display("%0t: offset_seconds expected %0d got %0d", $time,
                     $signed(want.offset_seconds), $signed(data[31:0]));
            errors++;
         end
         if (data[35:32] != want.name_length) begin
            $display("%0t: name_length expected %0d got %0d", $time,
                     want.name_length, data[35:32]);
            errors++;
         end
         if (data[36] != want.universal_name) begin
            $display("%0t: universal_name expected %b got %b", $time,
                     want.universal_name, data[36]);
            errors++;
         end
         if (user != want.used_default) begin
            $display("%0t: used_default expected %b got %b", $time, want.used_default, user);
            errors++;
         end
      endfunction
   endclass

   logic                       clock = 1'b0;
   logic                       reset = 1'b1;
   logic                       req_tvalid = 1'b0;
   logic                       req_tready;
   logic [7:0]                 req_tdata = '0;
   logic                       req_tuser = 1'b0;
   logic                       rsp_tvalid;
   logic                       rsp_tready = 1'b0;
   logic [RSP_BITS-1:0]        rsp_tdata;
   logic                       rsp_tuser;
   logic                       csr_valid = 1'b0;
   logic                       csr_ready;
   logic [tzp_pkg::CFG_W-1:0]  csr_data = '0;

   zone_scoreboard zones;
   int sender_idle_pct = 0;
   int stall_pct = 0;
   int hold_ask = 0;
   int hold_seen = 0;
   int hold_left = 0;
   int items_sent = 0;
   int cycle_count = 0;

   tz_offset_string_parser u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   // Result side: random stalls, plus a long hold-off whenever the main flow asks for one.
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (hold_ask != hold_seen) begin
         hold_seen = hold_ask;
         hold_left = HOLD_CYCLES;
         rsp_tready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left = hold_left - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= stall_pct);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) zones.check_result(rsp_tdata, rsp_tuser);
   end

   task automatic send_item(input logic [7:0] ch, input logic absent);
      while ($urandom_range(99) < sender_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= ch;
      req_tuser <= absent;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      zones.note_input(ch, absent);
      items_sent++;
   endtask

   task automatic send_text(input string s);
      foreach (s[i]) send_item(s[i], 1'b0);
      send_item(tzp_pkg::CHAR_NUL, 1'b0);
   endtask

   task automatic write_default(input logic signed [tzp_pkg::CFG_W-1:0] value);
      csr_valid <= 1'b1;
      csr_data <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      zones.set_default(value);
      csr_valid <= 1'b0;
   endtask

   // Waits until every result has been taken, then lets the pipeline drain.
   task automatic drain();
      req_tvalid <= 1'b0;
      while (zones.pending.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   function automatic logic [7:0] zone_letter();
      string hot = "GMTUC";
      logic [7:0] base;
      if ($urandom_range(3) == 0) return hot[$urandom_range(4)];
      base = $urandom_range(1) ? tzp_pkg::CHAR_UC_A : tzp_pkg::CHAR_LC_A;
      return base + 8'($urandom_range(25));
   endfunction

   function automatic logic [7:0] noise_byte();
      return 8'($urandom_range(255, 1));
   endfunction

   function automatic logic [7:0] digit_byte();
      return tzp_pkg::CHAR_ZERO + 8'($urandom_range(9));
   endfunction

   // Mostly well-formed zone strings with random content; some noise, long text and aborts.
   task automatic send_zone_string();
      logic [7:0] text[$];
      string name;
      int count;
      int pad_to;
      if ($urandom_range(99) < 15) begin
         case ($urandom_range(5))
            0:       name = "GMT";
            1:       name = "UTC";
            2:       name = "GMTX";
            3:       name = "gmt";
            4:       name = "UT";
            default: name = "UTX";
         endcase
         foreach (name[i]) text.push_back(name[i]);
      end else begin
         count = ($urandom_range(9) == 0) ? $urandom_range(12) : $urandom_range(5);
         repeat (count) text.push_back(zone_letter());
      end
      if ($urandom_range(99) < 35) text.push_back(tzp_pkg::CHAR_MINUS);
      if ($urandom_range(99) < 30) text.push_back(tzp_pkg::CHAR_PLUS);
      count = ($urandom_range(9) == 0) ? $urandom_range(6, 4) : $urandom_range(3);
      repeat (count) text.push_back(digit_byte());
      if ($urandom_range(9) == 0) begin
         text.push_back(tzp_pkg::CHAR_PLUS);
         repeat ($urandom_range(2)) text.push_back(digit_byte());
      end
      if ($urandom_range(1)) begin
         text.push_back(tzp_pkg::CHAR_COLON);
         repeat ($urandom_range(3)) text.push_back(digit_byte());
         if ($urandom_range(1)) begin
            text.push_back(tzp_pkg::CHAR_COLON);
            count = ($urandom_range(9) == 0) ? 5 : $urandom_range(3);
            repeat (count) text.push_back(digit_byte());
         end
      end
      if ($urandom_range(99) < 15) text.insert($urandom_range(text.size()), noise_byte());
      if ($urandom_range(99) < 15) repeat ($urandom_range(4, 1)) text.push_back(noise_byte());
      if ($urandom_range(99) < 5) begin
         pad_to = $urandom_range(80, 60);
         while (text.size() < pad_to) text.push_back(noise_byte());
      end
      foreach (text[i]) send_item(text[i], 1'b0);
      if ($urandom_range(9) == 0) send_item(8'($urandom_range(255)), 1'b1);
      else send_item(tzp_pkg::CHAR_NUL, 1'b0);
   endtask

   initial begin
      int goal;
      zones = new();
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Directed: absent variable at the reset default, empty string, universal names.
      send_item(8'hFF, 1'b1);
      send_text("");
      send_text("GMT-12");
      send_text("UTC99999:59:60");

      for (int phase = 0; phase < 5; phase++) begin
         drain();
         case (phase)
            0: begin
               write_default(-18'sd86400);
               sender_idle_pct = 0;
               stall_pct = 0;
            end
            1: begin
               write_default(18'sd86400);
               sender_idle_pct = 85;
               stall_pct = 0;
            end
            2: begin
               write_default('0);
               sender_idle_pct = 0;
               stall_pct = 85;
            end
            3: begin
               write_default(tzp_pkg::CFG_W'(int'($urandom_range(172800)) - 86400));
               sender_idle_pct = 20;
               stall_pct = 20;
            end
            default: begin
               write_default(tzp_pkg::CFG_W'(int'($urandom_range(172800)) - 86400));
               sender_idle_pct = 0;
               stall_pct = 0;
               hold_ask++;
            end
         endcase
         goal = items_sent + PHASE_ITEMS;
         while (items_sent < goal) send_zone_string();
      end

      drain();
      if (zones.errors == 0) $display("SCOREBOARD CLEAN");
      else $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule
